@@ rtl/fen_pkg.sv @@
package fen_pkg;

    // ASCII codes used by the parser
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_EIGHT = 8'h38;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_UP_K  = 8'h4B;
    localparam logic [7:0] CHAR_UP_Q  = 8'h51;
    localparam logic [7:0] CHAR_LOW_K = 8'h6B;
    localparam logic [7:0] CHAR_LOW_Q = 8'h71;

    // Field numbers within the string
    localparam logic [2:0] FIELD_PLACEMENT = 3'd0;
    localparam logic [2:0] FIELD_MOVER     = 3'd1;
    localparam logic [2:0] FIELD_CASTLING  = 3'd2;
    localparam logic [2:0] FIELD_PASSING   = 3'd3;
    localparam logic [2:0] FIELD_FULLMOVE  = 3'd5;
    localparam logic [2:0] FIELD_LAST      = 3'd7;

    // Castling right bit positions
    localparam int CASTLE_WHITE_KING  = 6;
    localparam int CASTLE_WHITE_QUEEN = 2;
    localparam int CASTLE_BLACK_KING  = 62;
    localparam int CASTLE_BLACK_QUEEN = 58;
    localparam logic [63:0] CASTLE_ALLOWED =
        (64'd1 << CASTLE_WHITE_KING)  | (64'd1 << CASTLE_WHITE_QUEEN) |
        (64'd1 << CASTLE_BLACK_KING)  | (64'd1 << CASTLE_BLACK_QUEEN);

    // Board walk limits
    localparam logic [4:0]  ROW_START   = 5'd7;
    localparam logic [4:0]  ROW_BELOW   = 5'd31;
    localparam logic [4:0]  COL_MAX     = 5'd31;
    localparam logic [1:0]  COUNT_MAX   = 2'd3;
    localparam logic [7:0]  FILE_NONE   = 8'hFF;
    localparam logic [15:0] MOVE_MAX    = 16'hFFFF;

    // Piece kinds, index into the kind masks
    localparam int          NUM_KINDS   = 6;
    localparam logic [2:0]  KIND_PAWN   = 3'd0;
    localparam logic [2:0]  KIND_ROOK   = 3'd1;
    localparam logic [2:0]  KIND_KNIGHT = 3'd2;
    localparam logic [2:0]  KIND_BISHOP = 3'd3;
    localparam logic [2:0]  KIND_QUEEN  = 3'd4;
    localparam logic [2:0]  KIND_KING   = 3'd5;

    typedef struct packed {
        logic       hit;
        logic       white;
        logic [2:0] kind;
    } piece_t;

    function automatic piece_t decode_piece(input logic [7:0] c);
        piece_t p;
        p.hit   = 1'b1;
        p.white = ~c[5];
        unique case (c)
            8'h50, 8'h70: p.kind = KIND_PAWN;
            8'h52, 8'h72: p.kind = KIND_ROOK;
            8'h4E, 8'h6E: p.kind = KIND_KNIGHT;
            8'h42, 8'h62: p.kind = KIND_BISHOP;
            8'h51, 8'h71: p.kind = KIND_QUEEN;
            8'h4B, 8'h6B: p.kind = KIND_KING;
            default:
            begin
                p.hit  = 1'b0;
                p.kind = KIND_PAWN;
            end
        endcase
        return p;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

@@ rtl/fen_position_parser.sv @@
// FEN position parser: one byte per transfer, bitboards out on the last byte.
// Result path: the last byte goes from the input register straight into the
// result register; it waits in the input register while the result is stalled.
// Throughput: one byte per cycle unless a last byte waits on a full result register.
// Reset: rst_n clears the parse state to an empty position and drops all valids.
module fen_position_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] white_mask,
    output logic [63:0] black_mask,
    output logic [63:0] pawn_mask,
    output logic [63:0] rook_mask,
    output logic [63:0] knight_mask,
    output logic [63:0] bishop_mask,
    output logic [63:0] queen_mask,
    output logic [63:0] king_mask,
    output logic [63:0] passing_target,
    output logic [63:0] castling_marks,
    output logic [7:0]  side_to_move,
    output logic [15:0] move_number
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Parse state
    logic [63:0] white_reg,   white_next;
    logic [63:0] black_reg,   black_next;
    logic [63:0] kind_reg  [fen_pkg::NUM_KINDS];
    logic [63:0] kind_next [fen_pkg::NUM_KINDS];
    logic [63:0] passing_reg, passing_next;
    logic [63:0] castle_reg,  castle_next;
    logic [7:0]  mover_reg,   mover_next;
    logic [2:0]  field_reg,   field_next;
    logic        inside_reg,  inside_next;
    logic [4:0]  col_reg,     col_next;
    logic [4:0]  row_reg,     row_next;
    logic [1:0]  count_reg,   count_next;
    logic [7:0]  pending_reg, pending_next;
    logic [15:0] accum_reg,   accum_next;
    logic        done_reg,    done_next;

    // Result register
    logic        out_valid_reg;
    logic [63:0] white_out_reg, black_out_reg;
    logic [63:0] kind_out_reg [fen_pkg::NUM_KINDS];
    logic [63:0] passing_out_reg, castle_out_reg;
    logic [7:0]  mover_out_reg;
    logic [15:0] accum_out_reg;

    logic advance;

    // Handshake: the held byte moves on unless it closes a string and the
    // result register is still full
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Next parse state for the held byte
    always_comb
    begin
        logic [7:0]         c;
        logic [1:0]         count_eff;
        logic [5:0]         col_sum;
        logic [63:0]        square;
        logic [7:0]         rank;
        logic [19:0]        times_ten;
        fen_pkg::piece_t    piece;

        c         = byte_reg;
        count_eff = inside_reg ? count_reg : 2'd0;
        col_sum   = 6'd0;
        square    = 64'd0;
        rank      = c - fen_pkg::CHAR_ONE;
        times_ten = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                    + {16'd0, c[3:0]};
        piece     = fen_pkg::decode_piece(c);

        white_next   = white_reg;
        black_next   = black_reg;
        kind_next    = kind_reg;
        passing_next = passing_reg;
        castle_next  = castle_reg;
        mover_next   = mover_reg;
        field_next   = field_reg;
        inside_next  = inside_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        accum_next   = accum_reg;
        done_next    = done_reg;

        if (fen_pkg::is_blank(c))
        begin
            // whitespace closes a token
            if (inside_reg)
            begin
                if (field_reg != fen_pkg::FIELD_LAST)
                begin
                    field_next = field_reg + 3'd1;
                end
                inside_next = 1'b0;
            end
        end
        else
        begin
            inside_next = 1'b1;
            case (field_reg)
                fen_pkg::FIELD_PLACEMENT:
                begin
                    if ((c >= fen_pkg::CHAR_ONE) && (c <= fen_pkg::CHAR_EIGHT))
                    begin
                        // digit skips squares
                        col_sum  = {1'b0, col_reg} + {2'd0, c[3:0]};
                        col_next = (col_sum > {1'b0, fen_pkg::COL_MAX})
                                   ? fen_pkg::COL_MAX : col_sum[4:0];
                    end
                    else if (c == fen_pkg::CHAR_SLASH)
                    begin
                        // next rank down; below the board it stays below
                        if ((row_reg == 5'd0) || (row_reg >= 5'd8))
                        begin
                            row_next = fen_pkg::ROW_BELOW;
                        end
                        else
                        begin
                            row_next = row_reg - 5'd1;
                        end
                        col_next = 5'd0;
                    end
                    else
                    begin
                        if (piece.hit && (row_reg < 5'd8) && (col_reg < 5'd8))
                        begin
                            square = 64'd1 << {row_reg[2:0], col_reg[2:0]};
                            kind_next[piece.kind] = kind_reg[piece.kind] | square;
                            if (piece.white)
                            begin
                                white_next = white_reg | square;
                            end
                            else
                            begin
                                black_next = black_reg | square;
                            end
                        end
                        col_next = (col_reg == fen_pkg::COL_MAX)
                                   ? fen_pkg::COL_MAX : col_reg + 5'd1;
                    end
                end
                fen_pkg::FIELD_MOVER:
                begin
                    if (count_eff == 2'd0)
                    begin
                        mover_next = c;
                    end
                end
                fen_pkg::FIELD_CASTLING:
                begin
                    case (c)
                        fen_pkg::CHAR_UP_K:
                            castle_next[fen_pkg::CASTLE_WHITE_KING] = 1'b1;
                        fen_pkg::CHAR_UP_Q:
                            castle_next[fen_pkg::CASTLE_WHITE_QUEEN] = 1'b1;
                        fen_pkg::CHAR_LOW_K:
                            castle_next[fen_pkg::CASTLE_BLACK_KING] = 1'b1;
                        fen_pkg::CHAR_LOW_Q:
                            castle_next[fen_pkg::CASTLE_BLACK_QUEEN] = 1'b1;
                        default: ;
                    endcase
                end
                fen_pkg::FIELD_PASSING:
                begin
                    // first char is the file, second the rank
                    if (count_eff == 2'd0)
                    begin
                        pending_next = (c == fen_pkg::CHAR_DASH)
                                       ? fen_pkg::FILE_NONE : c - fen_pkg::CHAR_LOW_A;
                    end
                    else if (count_eff == 2'd1)
                    begin
                        if ((pending_reg < 8'd8) && (rank < 8'd8))
                        begin
                            passing_next = 64'd1 << {rank[2:0], pending_reg[2:0]};
                        end
                    end
                end
                fen_pkg::FIELD_FULLMOVE:
                begin
                    if (!done_reg)
                    begin
                        if ((c >= fen_pkg::CHAR_ZERO) && (c <= fen_pkg::CHAR_NINE))
                        begin
                            accum_next = (times_ten > {4'd0, fen_pkg::MOVE_MAX})
                                         ? fen_pkg::MOVE_MAX : times_ten[15:0];
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            count_next = (count_eff == fen_pkg::COUNT_MAX)
                         ? fen_pkg::COUNT_MAX : count_eff + 2'd1;
        end
    end

    // Input register and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            byte_reg     <= 8'd0;
            last_reg     <= 1'b0;
            white_reg    <= 64'd0;
            black_reg    <= 64'd0;
            for (int k = 0; k < fen_pkg::NUM_KINDS; k++)
            begin
                kind_reg[k] <= 64'd0;
            end
            passing_reg  <= 64'd0;
            castle_reg   <= 64'd0;
            mover_reg    <= 8'd0;
            field_reg    <= fen_pkg::FIELD_PLACEMENT;
            inside_reg   <= 1'b0;
            col_reg      <= 5'd0;
            row_reg      <= fen_pkg::ROW_START;
            count_reg    <= 2'd0;
            pending_reg  <= 8'd0;
            accum_reg    <= 16'd0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
                byte_reg     <= text_byte;
                last_reg     <= is_last;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (last_reg)
                begin
                    // string done: back to an empty position
                    white_reg   <= 64'd0;
                    black_reg   <= 64'd0;
                    for (int k = 0; k < fen_pkg::NUM_KINDS; k++)
                    begin
                        kind_reg[k] <= 64'd0;
                    end
                    passing_reg <= 64'd0;
                    castle_reg  <= 64'd0;
                    mover_reg   <= 8'd0;
                    field_reg   <= fen_pkg::FIELD_PLACEMENT;
                    inside_reg  <= 1'b0;
                    col_reg     <= 5'd0;
                    row_reg     <= fen_pkg::ROW_START;
                    count_reg   <= 2'd0;
                    pending_reg <= 8'd0;
                    accum_reg   <= 16'd0;
                    done_reg    <= 1'b0;
                end
                else
                begin
                    white_reg   <= white_next;
                    black_reg   <= black_next;
                    kind_reg    <= kind_next;
                    passing_reg <= passing_next;
                    castle_reg  <= castle_next;
                    mover_reg   <= mover_next;
                    field_reg   <= field_next;
                    inside_reg  <= inside_next;
                    col_reg     <= col_next;
                    row_reg     <= row_next;
                    count_reg   <= count_next;
                    pending_reg <= pending_next;
                    accum_reg   <= accum_next;
                    done_reg    <= done_next;
                end
            end
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            white_out_reg   <= white_next;
            black_out_reg   <= black_next;
            kind_out_reg    <= kind_next;
            passing_out_reg <= passing_next;
            castle_out_reg  <= castle_next;
            mover_out_reg   <= mover_next;
            accum_out_reg   <= accum_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign white_mask     = white_out_reg;
    assign black_mask     = black_out_reg;
    assign pawn_mask      = kind_out_reg[fen_pkg::KIND_PAWN];
    assign rook_mask      = kind_out_reg[fen_pkg::KIND_ROOK];
    assign knight_mask    = kind_out_reg[fen_pkg::KIND_KNIGHT];
    assign bishop_mask    = kind_out_reg[fen_pkg::KIND_BISHOP];
    assign queen_mask     = kind_out_reg[fen_pkg::KIND_QUEEN];
    assign king_mask      = kind_out_reg[fen_pkg::KIND_KING];
    assign passing_target = passing_out_reg;
    assign castling_marks = castle_out_reg;
    assign side_to_move   = mover_out_reg;
    assign move_number    = accum_out_reg;

endmodule

@@ rtl/fen_checker.sv @@
module fen_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] white_mask,
    input logic [63:0] black_mask,
    input logic [63:0] pawn_mask,
    input logic [63:0] rook_mask,
    input logic [63:0] knight_mask,
    input logic [63:0] bishop_mask,
    input logic [63:0] queen_mask,
    input logic [63:0] king_mask,
    input logic [63:0] passing_target,
    input logic [63:0] castling_marks,
    input logic [7:0]  side_to_move,
    input logic [15:0] move_number
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(white_mask)
        && $stable(king_mask) && $stable(move_number) && $stable(side_to_move))
        else $error("stalled result changed");

    // with no result waiting the input is always open
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result waiting");

    // no square is both colours, and coloured squares are exactly the piece squares
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((white_mask & black_mask) == 64'd0)
        && ((pawn_mask | rook_mask | knight_mask | bishop_mask | queen_mask
             | king_mask) == (white_mask | black_mask)))
        else $error("colour and kind masks disagree");

    // at most one en-passant square
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(passing_target))
        else $error("en-passant target not one-hot");

    // castling only on the four bits in CASTLE_ALLOWED (c1, g1, c8, g8)
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((castling_marks & ~fen_pkg::CASTLE_ALLOWED) == 64'd0))
        else $error("stray castling bit");

endmodule

bind fen_position_parser fen_checker u_fen_checker (.*);
